### hdl/task_period_jitter_monitor_unit_assert.svh
// assertion macros used by the monitor unit rtl
`ifndef TASK_PERIOD_JITTER_MONITOR_UNIT_ASSERT_SVH
`define TASK_PERIOD_JITTER_MONITOR_UNIT_ASSERT_SVH

`ifndef SYNTH
`define TPJM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("tpjm assertion failed");
`define TPJM_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("tpjm assertion failed");
`else
`define TPJM_ASSERT(label, clk, rst_n, prop)
`define TPJM_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### hdl/tpjm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tpjm_pkg;

    localparam int TASKS    = 8;
    localparam int SLOT_W   = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int TASK_W   = 5;
    localparam int CMD_W    = 2;
    localparam int PERIOD_W = 16;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(DATA_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_RECORD = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef logic [DATA_W-1:0]   t_word;
    typedef logic [PERIOD_W-1:0] t_period;
    typedef logic [SLOT_W-1:0]   t_slot;

endpackage
`default_nettype wire

### hdl/task_period_jitter_monitor_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Per-task period and jitter monitor. A command (record, query, clear) is taken when
// i_start is high and o_busy is low; exactly one result follows, shown for a single
// cycle with o_strobe, and the receiver cannot stall it. Clear, unused commands and
// out-of-range task slots never raise o_busy; their result comes in the cycle right
// after acceptance. A query or the first record of a task keeps o_busy high through
// S_DSTART, which starts the shared restoring divider that forms the average, and
// S_DIV, where the divider forms its 32 quotient bits (one per cycle) and the result
// is then registered. A later record first passes the interval, jitter and counter
// update states ahead of the divider. o_strobe comes in the cycle o_busy drops, and a
// new transaction can be taken in that same cycle.
`include "task_period_jitter_monitor_unit_assert.svh"
module task_period_jitter_monitor_unit (
    input  wire                   logic i_clk,
    input  wire                   logic i_rst_n,
    input  wire                   logic i_start,
    output logic                        o_busy,
    input  wire [tpjm_pkg::CMD_W-1:0]    i_command,
    input  wire [tpjm_pkg::TASK_W-1:0]   i_task_slot,
    input  wire tpjm_pkg::t_period      i_expected_period,
    input  wire tpjm_pkg::t_word        i_tick_now,
    output logic                        o_strobe,
    output logic                        o_accepted,
    output tpjm_pkg::t_period           o_period_out,
    output tpjm_pkg::t_word             o_samples_out,
    output tpjm_pkg::t_word             o_average_interval,
    output tpjm_pkg::t_word             o_worst_jitter,
    output tpjm_pkg::t_word             o_miss_count,
    output logic                        o_report_done
);
    import tpjm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INTV,
        S_JIT,
        S_UPD,
        S_DSTART,
        S_DIV
    } t_state;

    t_state             r_state;
    logic [TASKS-1:0]   r_seen;
    t_word              r_last    [TASKS];
    t_period            r_per_arr [TASKS];
    t_word              r_samples [TASKS];
    t_word              r_sum     [TASKS];
    t_word              r_peak    [TASKS];
    t_word              r_late    [TASKS];
    logic               r_done_flag;

    t_slot              r_slot;
    t_period            r_period;
    t_word              r_tick;
    t_word              r_interval;
    t_word              r_jitter;

    logic               r_strobe;
    logic               r_accepted;
    t_period            r_period_out;
    t_word              r_samples_out;
    t_word              r_avg;
    t_word              r_worst;
    t_word              r_miss;
    logic               r_report;

    logic               in_range;
    t_slot              in_slot;
    t_word              period_w;
    t_word              n_jitter;
    logic               div_start;
    logic               div_done;
    t_word              div_quo;

    assign in_range  = {1'b0, i_task_slot} < (TASK_W + 1)'(TASKS);
    assign in_slot   = i_task_slot[SLOT_W-1:0];
    assign period_w  = DATA_W'(r_period);
    assign div_start = (r_state == S_DSTART);

    always_comb begin
        if (r_interval >= period_w) begin
            n_jitter = r_interval - period_w;
        end else begin
            n_jitter = period_w - r_interval;
        end
    end

    tpjm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum[r_slot]),
        .i_divisor  (r_samples[r_slot]),
        .o_quotient (div_quo),
        .o_done     (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seen      <= '0;
            r_done_flag <= 1'b0;
            r_strobe    <= 1'b0;
            for (int k = 0; k < TASKS; k++) begin
                r_last[k]    <= '0;
                r_per_arr[k] <= '0;
                r_samples[k] <= '0;
                r_sum[k]     <= '0;
                r_peak[k]    <= '0;
                r_late[k]    <= '0;
            end
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_slot   <= in_slot;
                        r_period <= i_expected_period;
                        r_tick   <= i_tick_now;
                        if (i_command == CMD_CLEAR) begin
                            r_seen      <= '0;
                            r_done_flag <= 1'b0;
                            for (int k = 0; k < TASKS; k++) begin
                                r_last[k]    <= '0;
                                r_per_arr[k] <= '0;
                                r_samples[k] <= '0;
                                r_sum[k]     <= '0;
                                r_peak[k]    <= '0;
                                r_late[k]    <= '0;
                            end
                            r_strobe      <= 1'b1;
                            r_accepted    <= 1'b1;
                            r_period_out  <= '0;
                            r_samples_out <= '0;
                            r_avg         <= '0;
                            r_worst       <= '0;
                            r_miss        <= '0;
                            r_report      <= 1'b0;
                        end else if (in_range && i_command == CMD_QUERY) begin
                            r_done_flag <= 1'b1;
                            r_state     <= S_DSTART;
                        end else if (in_range && i_command == CMD_RECORD) begin
                            r_per_arr[in_slot] <= i_expected_period;
                            if (!r_seen[in_slot]) begin
                                // first record of the task marks the tick and adds no sample
                                r_seen[in_slot] <= 1'b1;
                                r_last[in_slot] <= i_tick_now;
                                r_state         <= S_DSTART;
                            end else begin
                                r_state <= S_INTV;
                            end
                        end else begin
                            r_strobe      <= 1'b1;
                            r_accepted    <= 1'b0;
                            r_period_out  <= '0;
                            r_samples_out <= '0;
                            r_avg         <= '0;
                            r_worst       <= '0;
                            r_miss        <= '0;
                            r_report      <= r_done_flag;
                        end
                    end
                end
                S_INTV: begin
                    r_interval     <= r_tick - r_last[r_slot];
                    r_last[r_slot] <= r_tick;
                    r_state        <= S_JIT;
                end
                S_JIT: begin
                    r_jitter          <= n_jitter;
                    r_samples[r_slot] <= r_samples[r_slot] + DATA_W'(1);
                    r_sum[r_slot]     <= r_sum[r_slot] + r_interval;
                    r_state           <= S_UPD;
                end
                S_UPD: begin
                    if (r_jitter > r_peak[r_slot]) begin
                        r_peak[r_slot] <= r_jitter;
                    end
                    // deadline miss: interval beyond period plus one tick
                    if (r_interval > period_w + DATA_W'(1)) begin
                        r_late[r_slot] <= r_late[r_slot] + DATA_W'(1);
                    end
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_strobe      <= 1'b1;
                        r_accepted    <= 1'b1;
                        r_period_out  <= r_per_arr[r_slot];
                        r_samples_out <= r_samples[r_slot];
                        r_avg         <= (r_samples[r_slot] == '0) ? '0 : div_quo;
                        r_worst       <= r_peak[r_slot];
                        r_miss        <= r_late[r_slot];
                        r_report      <= r_done_flag;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy             = (r_state != S_IDLE);
    assign o_strobe           = r_strobe;
    assign o_accepted         = r_accepted;
    assign o_period_out       = r_period_out;
    assign o_samples_out      = r_samples_out;
    assign o_average_interval = r_avg;
    assign o_worst_jitter     = r_worst;
    assign o_miss_count       = r_miss;
    assign o_report_done      = r_report;

    `TPJM_ASSERT(a_reject_zero, i_clk, i_rst_n,
        (o_strobe && !o_accepted) |->
        (o_samples_out == '0 && o_miss_count == '0 && o_worst_jitter == '0))
    `TPJM_ASSERT(a_long_cmd_busy, i_clk, i_rst_n,
        (i_start && !o_busy && in_range &&
         (i_command == CMD_RECORD || i_command == CMD_QUERY)) |=> o_busy)
    `TPJM_ASSERT(a_div_done_state, i_clk, i_rst_n, div_done |-> (r_state == S_DIV))
    `TPJM_ASSERT(a_strobe_idle, i_clk, i_rst_n, o_strobe |-> !o_busy)
    `TPJM_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (!o_busy && !o_strobe))

endmodule
`default_nettype wire

### hdl/tpjm_div.sv
`timescale 1ns / 1ps
`default_nettype none
module tpjm_div (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_start,
    input  wire tpjm_pkg::t_word     i_dividend,
    input  wire tpjm_pkg::t_word     i_divisor,
    output tpjm_pkg::t_word          o_quotient,
    output logic                     o_done
);
    import tpjm_pkg::*;

    t_word              r_rem;
    t_word              r_quo;
    t_word              r_dvs;
    logic [CNT_W-1:0]   r_count;
    logic               r_run;
    logic               r_done;
    logic [DATA_W:0]    n_shift;
    logic [DATA_W:0]    n_diff;

    // one quotient bit per cycle, restoring
    always_comb begin
        n_shift = {r_rem, r_quo[DATA_W-1]};
        n_diff  = n_shift - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem   <= '0;
                r_quo   <= i_dividend;
                r_dvs   <= i_divisor;
                r_count <= '0;
                r_run   <= 1'b1;
            end else if (r_run) begin
                if (!n_diff[DATA_W]) begin
                    r_rem <= n_diff[DATA_W-1:0];
                    r_quo <= {r_quo[DATA_W-2:0], 1'b1};
                end else begin
                    r_rem <= n_shift[DATA_W-1:0];
                    r_quo <= {r_quo[DATA_W-2:0], 1'b0};
                end
                r_count <= r_count + CNT_W'(1);
                if (r_count == CNT_W'(DATA_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import tpjm_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 600000;
    localparam int SETTLE_CYCLES = 50;

    typedef struct packed {
        logic    accepted;
        t_period period;
        t_word   samples;
        t_word   average;
        t_word   jitter;
        t_word   misses;
        logic    report_done;
    } monitor_result_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_start;
    logic                o_busy;
    logic [CMD_W-1:0]    i_command;
    logic [TASK_W-1:0]   i_task_slot;
    t_period             i_expected_period;
    t_word               i_tick_now;
    logic                o_strobe;
    logic                o_accepted;
    t_period             o_period_out;
    t_word               o_samples_out;
    t_word               o_average_interval;
    t_word               o_worst_jitter;
    t_word               o_miss_count;
    logic                o_report_done;

    // predictor copy of the per-task monitor state
    logic    mon_seen     [TASKS];
    t_word   mon_last     [TASKS];
    t_period mon_period   [TASKS];
    t_word   mon_samples  [TASKS];
    t_word   mon_sum      [TASKS];
    t_word   mon_peak     [TASKS];
    t_word   mon_late     [TASKS];
    logic    mon_reported;

    // stimulus-side tick and period per task, so records form plausible schedules
    t_word   sched_tick   [TASKS];
    t_period sched_period [TASKS];

    monitor_result_t expected_results[$];
    int  mismatch_count = 0;
    int  cycle_count = 0;
    bit  idle_on = 1'b1;

    task_period_jitter_monitor_unit u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_command          (i_command),
        .i_task_slot        (i_task_slot),
        .i_expected_period  (i_expected_period),
        .i_tick_now         (i_tick_now),
        .o_strobe           (o_strobe),
        .o_accepted         (o_accepted),
        .o_period_out       (o_period_out),
        .o_samples_out      (o_samples_out),
        .o_average_interval (o_average_interval),
        .o_worst_jitter     (o_worst_jitter),
        .o_miss_count       (o_miss_count),
        .o_report_done      (o_report_done)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void clear_monitor();
        for (int s = 0; s < TASKS; s++) begin
            mon_seen[s]    = 1'b0;
            mon_last[s]    = '0;
            mon_period[s]  = '0;
            mon_samples[s] = '0;
            mon_sum[s]     = '0;
            mon_peak[s]    = '0;
            mon_late[s]    = '0;
        end
        mon_reported = 1'b0;
    endfunction

    function automatic monitor_result_t predict_monitor(input logic [CMD_W-1:0] cmd,
                                                        input logic [TASK_W-1:0] slot,
                                                        input t_period period,
                                                        input t_word tick);
        monitor_result_t r;
        t_word interval;
        t_word wide_period;
        t_word jit;
        int s;
        r = '0;
        s = int'(slot);
        wide_period = {16'd0, period};
        if (cmd == CMD_CLEAR) begin
            clear_monitor();
            r.accepted = 1'b1;
        end else if ((cmd == CMD_RECORD || cmd == CMD_QUERY) && s < TASKS) begin
            if (cmd == CMD_RECORD) begin
                mon_period[s] = period;
                if (!mon_seen[s]) begin
                    mon_seen[s] = 1'b1;
                    mon_last[s] = tick;
                end else begin
                    interval = tick - mon_last[s];
                    mon_last[s] = tick;
                    mon_samples[s] = mon_samples[s] + 32'd1;
                    mon_sum[s] = mon_sum[s] + interval;
                    jit = (interval >= wide_period) ? interval - wide_period
                                                    : wide_period - interval;
                    if (jit > mon_peak[s])
                        mon_peak[s] = jit;
                    if (interval > wide_period + 32'd1)
                        mon_late[s] = mon_late[s] + 32'd1;
                end
            end else begin
                mon_reported = 1'b1;
            end
            r.accepted = 1'b1;
            r.period   = mon_period[s];
            r.samples  = mon_samples[s];
            r.average  = (mon_samples[s] != 0) ? mon_sum[s] / mon_samples[s] : '0;
            r.jitter   = mon_peak[s];
            r.misses   = mon_late[s];
        end
        r.report_done = mon_reported;
        return r;
    endfunction

    task automatic compare_field(input string name, input t_word want, input t_word got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // predict on each accepted transaction first, then check any result in the same edge
    always @(posedge i_clk) begin : check_results
        monitor_result_t want;
        if (i_rst_n) begin
            if (i_start && !o_busy)
                expected_results.push_back(predict_monitor(i_command, i_task_slot,
                                                           i_expected_period, i_tick_now));
            if (o_strobe === 1'b1) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, got %0h",
                             $time, o_samples_out);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("accepted", t_word'(want.accepted), t_word'(o_accepted));
                    compare_field("period_out", t_word'(want.period), t_word'(o_period_out));
                    compare_field("samples_out", want.samples, o_samples_out);
                    compare_field("average_interval", want.average, o_average_interval);
                    compare_field("worst_jitter", want.jitter, o_worst_jitter);
                    compare_field("miss_count", want.misses, o_miss_count);
                    compare_field("report_done", t_word'(want.report_done),
                                  t_word'(o_report_done));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("task_period_jitter_monitor_unit verification failed");
            $finish;
        end
    end

    task automatic insert_gap(input int cycles);
        i_start           <= 1'b0;
        i_command         <= CMD_W'($urandom);
        i_task_slot       <= TASK_W'($urandom);
        i_expected_period <= PERIOD_W'($urandom);
        i_tick_now        <= $urandom;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [TASK_W-1:0] slot,
                                input t_period period, input t_word tick);
        i_command         <= cmd;
        i_task_slot       <= slot;
        i_expected_period <= period;
        i_tick_now        <= tick;
        i_start           <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        if (idle_on && $urandom_range(99) < 27)
            insert_gap(($urandom_range(1) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 45));
    endtask

    task automatic wait_for_drain(input int max_cycles);
        int waited;
        waited = 0;
        i_start <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0 && waited < max_cycles) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    task automatic test_queries_after_reset();
        send_command(CMD_QUERY, 5'd0, 16'h0000, 32'h0000_0000);
        send_command(CMD_QUERY, TASK_W'(TASKS - 1), 16'hFFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_record_extremes();
        // zero period, interval crosses the tick wrap
        send_command(CMD_RECORD, 5'd1, 16'h0000, 32'hFFFF_FFF0);
        send_command(CMD_RECORD, 5'd1, 16'h0000, 32'h0000_0005);
        // full period: one tick late is fine, two ticks late is a miss
        send_command(CMD_RECORD, 5'd2, 16'hFFFF, 32'h0000_0000);
        send_command(CMD_RECORD, 5'd2, 16'hFFFF, 32'h0001_0000);
        send_command(CMD_RECORD, 5'd2, 16'hFFFF, 32'h0002_0001);
        send_command(CMD_RECORD, 5'd2, 16'hFFFF, 32'h0002_000B);
        send_command(CMD_RECORD, 5'd2, 16'hFFFF, 32'h0002_000B);
        send_command(CMD_QUERY, 5'd2, 16'h0000, 32'h0000_0000);
    endtask

    task automatic test_out_of_range_slot();
        send_command(CMD_RECORD, TASK_W'(TASKS), 16'hFFFF, 32'hFFFF_FFFF);
        send_command(CMD_QUERY, 5'd31, 16'hFFFF, 32'hFFFF_FFFF);
        send_command(CMD_RECORD, 5'h10, 16'h5555, 32'hAAAA_AAAA);
    endtask

    task automatic test_unused_command();
        send_command(CMD_UNUSED, 5'd0, 16'h1234, 32'h0000_0001);
        send_command(CMD_UNUSED, 5'd31, 16'hFFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_clear_all();
        send_command(CMD_CLEAR, 5'd31, 16'hFFFF, 32'hFFFF_FFFF);
        send_command(CMD_QUERY, 5'd2, 16'h0000, 32'h0000_0000);
        send_command(CMD_CLEAR, 5'd0, 16'h0000, 32'h0000_0000);
    endtask

    task automatic test_random_traffic(input int count);
        int roll;
        int kind;
        int s;
        t_word step;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            s = $urandom_range(TASKS - 1);
            if (roll < 64) begin
                roll = $urandom_range(19);
                if (roll == 0)
                    sched_period[s] = PERIOD_W'($urandom);
                else if (roll == 1)
                    sched_period[s] = PERIOD_W'($urandom_range(1, 1000));
                kind = $urandom_range(9);
                case (kind)
                    6: step = sched_period[s] + 1;
                    7: step = sched_period[s] + 2;
                    8: step = $urandom;
                    9: step = $urandom_range(3);
                    default: step = sched_period[s] + $urandom_range(6) - 3;
                endcase
                sched_tick[s] = sched_tick[s] + step;
                send_command(CMD_RECORD, TASK_W'(s), sched_period[s], sched_tick[s]);
            end else if (roll < 82) begin
                send_command(CMD_QUERY, TASK_W'(s), PERIOD_W'($urandom), $urandom);
            end else if (roll < 90) begin
                send_command(($urandom_range(1) == 0) ? CMD_RECORD : CMD_QUERY,
                             TASK_W'($urandom_range(TASKS, 31)), PERIOD_W'($urandom),
                             $urandom);
            end else if (roll < 94) begin
                send_command(CMD_UNUSED, TASK_W'($urandom), PERIOD_W'($urandom), $urandom);
            end else if (roll == 94) begin
                send_command(CMD_CLEAR, TASK_W'($urandom), PERIOD_W'($urandom), $urandom);
            end else begin
                // stray record with unrelated tick and period
                send_command(CMD_RECORD, TASK_W'(s), PERIOD_W'($urandom), $urandom);
            end
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_start           <= 1'b0;
        i_command         <= '0;
        i_task_slot       <= '0;
        i_expected_period <= '0;
        i_tick_now        <= '0;
        clear_monitor();
        for (int s = 0; s < TASKS; s++) begin
            sched_tick[s]   = ($urandom_range(3) == 0) ? 32'hFFFF_F000 + $urandom_range(4095)
                                                       : $urandom;
            sched_period[s] = PERIOD_W'($urandom_range(1, 1000));
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_queries_after_reset();
        test_record_extremes();
        test_out_of_range_slot();
        test_unused_command();
        test_clear_all();
        test_random_traffic(450);
        idle_on = 1'b0;
        test_random_traffic(200);
        idle_on = 1'b1;
        wait_for_drain(2000);
        test_random_traffic(550);

        wait_for_drain(2000);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0t: results missing, expected %0d more, got 0",
                     $time, expected_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("task_period_jitter_monitor_unit verification clean");
        end else begin
            $display("task_period_jitter_monitor_unit verification failed");
        end
        $finish;
    end
endmodule

### files.f
+incdir+hdl
hdl/tpjm_pkg.sv
hdl/tpjm_div.sv
hdl/task_period_jitter_monitor_unit.sv
test/testbench.sv
